>>> src/two_wire_display_refresh_sequencer_macros.svh
// Assertion macros for the two-wire display refresh sequencer.
`ifndef TWO_WIRE_DISPLAY_REFRESH_SEQUENCER_MACROS_SVH
`define TWO_WIRE_DISPLAY_REFRESH_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DWRS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DWRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dwrs_pkg.sv
// Shared types and constants for the two-wire display refresh sequencer.
package dwrs_pkg;

	localparam int GRID_COUNT_DEF = 4;

	localparam int CFG_IDX_W = 2;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;

	localparam logic [7:0] FIXED_ADDR_RST = 8'h44;
	localparam logic [7:0] BRIGHTNESS_RST = 8'h8F;

	localparam logic [7:0] ADDR_BASE  = 8'hC0;
	localparam logic [2:0] BLANK_GRID = 3'd5;
	localparam logic [7:0] BLANK_SEG  = 8'h00;
	localparam logic [5:0] BYTE_TICKS = 6'd25;
	localparam logic [5:0] EDGE_TICKS = 6'd3;

	typedef struct packed {
		logic       clk_level;
		logic       dio_level;
		logic       byte_done;
		logic [7:0] byte_value;
		logic       busy_res;
		logic       refresh_done;
	} res_t;

endpackage

>>> src/dwrs_seq.sv
// Refresh sequencer state, grid store, config registers and per-item step logic.
module dwrs_seq #(
	parameter int GRID_COUNT = dwrs_pkg::GRID_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [1:0]                     req_type,
	input  logic [2:0]                     grid_index,
	input  logic [7:0]                     segment_bits,
	input  logic                           cfg_we,
	input  logic [dwrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output dwrs_pkg::res_t                 res,
	output logic                           running
);

	localparam int GIDX_W = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;
	localparam logic [3:0] LAST_STEP = 4'(2 * (GRID_COUNT + 1));
	localparam logic [2:0] GRID_LIM = 3'(GRID_COUNT);

	logic [7:0] fixed_addr_q;
	logic [7:0] brightness_q;
	logic [7:0] grid_q [GRID_COUNT];
	logic [3:0] frame_q;
	logic [5:0] phase_q;
	logic [7:0] shift_q;
	logic       clk_line_q;
	logic       dio_line_q;
	logic       running_q;

	logic [3:0] frame_d;
	logic [5:0] phase_d;
	logic [7:0] shift_d;
	logic       clk_line_d;
	logic       dio_line_d;
	logic       running_d;
	logic       load_en;

	logic       last_frame;
	logic       two_bytes;
	logic [2:0] grid_sel;
	logic       grid_real;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [5:0] body;
	logic [6:0] frame_len;
	logic [5:0] q_pos;
	logic       second;
	logic [4:0] r_pos;
	logic [8:0] r_mul;
	logic [3:0] quot;
	logic [4:0] rem3;
	logic [7:0] cur_shift;
	logic [5:0] s_pos;

	function automatic logic [7:0] ADDR_BASE_OR(input logic [2:0] g);
		return dwrs_pkg::ADDR_BASE | {5'b0, g};
	endfunction

	assign running = running_q;

	always_comb begin
		last_frame = (frame_q >= LAST_STEP);
		two_bytes  = !last_frame && frame_q[0];
		grid_sel   = frame_q[3:1];
		grid_real  = (grid_sel < GRID_LIM);
		if (last_frame) begin
			byte0 = brightness_q;
		end else if (!frame_q[0]) begin
			byte0 = fixed_addr_q;
		end else if (grid_real) begin
			byte0 = ADDR_BASE_OR(grid_sel);
		end else begin
			byte0 = ADDR_BASE_OR(dwrs_pkg::BLANK_GRID);
		end
		byte1     = grid_real ? grid_q[grid_sel[GIDX_W-1:0]] : dwrs_pkg::BLANK_SEG;
		body      = two_bytes ? 6'(2 * dwrs_pkg::BYTE_TICKS) : dwrs_pkg::BYTE_TICKS;
		frame_len = 7'(2 * dwrs_pkg::EDGE_TICKS) + {1'b0, body};
		q_pos     = phase_q - dwrs_pkg::EDGE_TICKS;
		second    = (q_pos >= dwrs_pkg::BYTE_TICKS);
		r_pos     = second ? 5'(q_pos - dwrs_pkg::BYTE_TICKS) : q_pos[4:0];
		// r/3 for r below 25 as (r*11)>>5
		r_mul     = 9'(r_pos) * 9'd11;
		quot      = r_mul[8:5];
		rem3      = r_pos - 5'(quot) * 5'd3;
		cur_shift = (r_pos == 5'd0) ? (second ? byte1 : byte0) : shift_q;
		s_pos     = q_pos - body;
	end

	always_comb begin
		frame_d    = frame_q;
		phase_d    = phase_q;
		shift_d    = shift_q;
		clk_line_d = clk_line_q;
		dio_line_d = dio_line_q;
		running_d  = running_q;
		load_en    = 1'b0;
		res        = '0;
		if (req_type == dwrs_pkg::REQ_TICK && running_q) begin
			if (phase_q < dwrs_pkg::EDGE_TICKS) begin
				clk_line_d = (phase_q < 6'd2);
				dio_line_d = (phase_q == 6'd0);
			end else if (q_pos < body) begin
				shift_d = cur_shift;
				if (r_pos == 5'(dwrs_pkg::BYTE_TICKS - 6'd1)) begin
					clk_line_d     = 1'b0;
					res.byte_done  = 1'b1;
					res.byte_value = shift_q;
				end else begin
					clk_line_d = (rem3[1:0] == 2'd2);
					if (rem3[1:0] != 2'd0) begin
						dio_line_d = cur_shift[quot[2:0]];
					end
				end
			end else begin
				clk_line_d = (s_pos < 6'd2);
				dio_line_d = (s_pos != 6'd0);
			end
			res.busy_res = 1'b1;
			if ({1'b0, phase_q} + 7'd1 >= frame_len) begin
				phase_d = '0;
				if (last_frame) begin
					running_d        = 1'b0;
					frame_d          = '0;
					res.refresh_done = 1'b1;
				end else begin
					frame_d = frame_q + 4'd1;
				end
			end else begin
				phase_d = phase_q + 6'd1;
			end
		end else begin
			if (!running_q) begin
				if (req_type == dwrs_pkg::REQ_LOAD && grid_index < GRID_LIM) begin
					load_en = 1'b1;
				end else if (req_type == dwrs_pkg::REQ_START) begin
					running_d = 1'b1;
					frame_d   = '0;
					phase_d   = '0;
				end
			end
			res.busy_res = running_d;
		end
		res.clk_level = clk_line_d;
		res.dio_level = dio_line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_addr_q <= dwrs_pkg::FIXED_ADDR_RST;
			brightness_q <= dwrs_pkg::BRIGHTNESS_RST;
			for (int i = 0; i < GRID_COUNT; i++) begin
				grid_q[i] <= '0;
			end
			frame_q    <= '0;
			phase_q    <= '0;
			shift_q    <= '0;
			clk_line_q <= 1'b1;
			dio_line_q <= 1'b1;
			running_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dwrs_pkg::REG_FIXED_ADDR) begin
					fixed_addr_q <= cfg_data;
				end else if (cfg_index == dwrs_pkg::REG_BRIGHTNESS) begin
					brightness_q <= cfg_data;
				end
			end
			if (step) begin
				if (load_en) begin
					grid_q[grid_index[GIDX_W-1:0]] <= segment_bits;
				end
				frame_q    <= frame_d;
				phase_q    <= phase_d;
				shift_q    <= shift_d;
				clk_line_q <= clk_line_d;
				dio_line_q <= dio_line_d;
				running_q  <= running_d;
			end
		end
	end

endmodule

>>> src/dwrs_out_reg.sv
// Result register between the sequencer step and the output channel.
module dwrs_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  dwrs_pkg::res_t res_in,
	input  logic           out_ready,
	output logic           out_valid,
	output logic           can_load,
	output dwrs_pkg::res_t res_out
);

	logic           valid_q;
	dwrs_pkg::res_t res_q;

	// Take a new result when empty or when the held one leaves this cycle.
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

>>> src/two_wire_display_refresh_sequencer.sv
// Top level of the two-wire display refresh sequencer.
// The result of an input transfer is registered and is valid in the next cycle; one result per input item.
// Throughput: one item per cycle while results are taken; the result register refills while being drained.
// Reset (arst_n low, async): lines high, idle, grid store zero, commands 0x44/0x8F.
// Config writes are taken every cycle (cfg_ready tied high).
`include "two_wire_display_refresh_sequencer_macros.svh"

module two_wire_display_refresh_sequencer #(
	parameter int GRID_COUNT = dwrs_pkg::GRID_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input item channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [2:0]                     grid_index,
	input  logic [7:0]                     segment_bits,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           clk_level,
	output logic                           dio_level,
	output logic                           byte_done,
	output logic [7:0]                     byte_value,
	output logic                           busy_res,
	output logic                           refresh_done,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dwrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data
);

	logic           step;
	logic           can_load;
	logic           running;
	dwrs_pkg::res_t step_res;
	dwrs_pkg::res_t held_res;

	// Registers are plain flops; accept a write whenever one is offered.
	assign cfg_ready = 1'b1;

	// Advance the sequencer on every input transfer. The result register
	// parts the two channels, so a stalled result only blocks input when
	// it is not leaving in the same cycle.
	assign in_ready = can_load;
	assign step     = in_valid && in_ready;

	// Sequencer: state, grid store, commands and the single-pass step logic.
	// Each tick advances the transaction in progress by one phase step.
	dwrs_seq #(
		.GRID_COUNT(GRID_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.req_type    (req_type),
		.grid_index  (grid_index),
		.segment_bits(segment_bits),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.res         (step_res),
		.running     (running)
	);

	// Hold the result until the output transfer completes.
	dwrs_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res_in   (step_res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.can_load (can_load),
		.res_out  (held_res)
	);

	assign clk_level    = held_res.clk_level;
	assign dio_level    = held_res.dio_level;
	assign byte_done    = held_res.byte_done;
	assign byte_value   = held_res.byte_value;
	assign busy_res     = held_res.busy_res;
	assign refresh_done = held_res.refresh_done;

	// A finished refresh drops the running state right after its last tick.
	`DWRS_ASSERT_NEXT(a_done_stops, step && step_res.refresh_done, !running, "refresh still running after final tick")
	// A byte completes on a low clock phase, and only while a refresh runs.
	`DWRS_ASSERT_SAME(a_byte_low, out_valid && byte_done, !clk_level && busy_res, "byte done with clock high or idle")
	// A held result that is not taken must block the next input.
	`DWRS_ASSERT_SAME(a_stall_blocks, out_valid && !out_ready, !in_ready, "input accepted over a stalled result")
	// A start taken while idle shows busy in its own result.
	`DWRS_ASSERT_NEXT(a_start_busy, step && !running && req_type == dwrs_pkg::REQ_START, running && busy_res, "start not reflected")

endmodule
